// ===== rtl/fifo_replacement_id_set_macros.svh =====
// Assertion macros shared by the identifier set modules.
// Depends on nothing; the asserting module must have clk and rst in scope.
`ifndef FIFO_REPLACEMENT_ID_SET_MACROS_SVH
`define FIFO_REPLACEMENT_ID_SET_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FRIS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FRIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fris_pkg.sv =====
// Shared types and constants for the FIFO-replacement identifier set.
// Depends on nothing; imported by the controller, datapath and top level.
package fris_pkg;

  // Built storage and identifier width
  localparam int DEPTH   = 16;
  localparam int ID_BITS = 32;

  // Fixed field widths of the ports
  localparam int IDENT_W = 32;
  localparam int CAP_W   = 5;
  localparam int OCC_W   = 5;

  // Derived widths
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WIDE_W = PTR_W + CNT_W + 2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [IDENT_W-1:0] ident;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [IDENT_W-1:0] evicted_ident;
    logic [OCC_W-1:0]   occupancy;
    logic [IDENT_W-1:0] listed_ident;
    logic               set_empty;
    logic               last;
  } res_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic access;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic dump_last;
  } sts_t;

endpackage

// ===== rtl/fris_ctrl.sv =====
// Controller state machine for the identifier set: sequences accesses and dumps.
// Depends on fris_pkg and fifo_replacement_id_set_macros.svh.
`include "fifo_replacement_id_set_macros.svh"

module fris_ctrl
  import fris_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic is_dump,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACCESS = 2'd1;
  localparam logic [1:0] ST_DUMP   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != ST_IDLE);

  // Decode next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (is_dump == OP_DUMP) ? ST_DUMP : ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        state_next = ST_IDLE;
      end
      ST_DUMP: begin
        cmd.emit = 1'b1;
        if (sts.dump_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `FRIS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `FRIS_ASSERT_NEXT(a_access_one, state == ST_ACCESS, state == ST_IDLE, "access took more than one cycle")
  `FRIS_ASSERT_NEXT(a_dump_ends, (state == ST_DUMP) && sts.dump_last, state == ST_IDLE, "dump ran past its last entry")

endmodule

// ===== rtl/fris_dp.sv =====
// Datapath of the identifier set: slot ring, parallel compare, eviction, result register.
// Depends on fris_pkg and fifo_replacement_id_set_macros.svh.
`include "fifo_replacement_id_set_macros.svh"

module fris_dp
  import fris_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [IDENT_W-1:0] ident,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_data,
  output sts_t               sts,
  output logic               done,
  output res_t               result
);

  logic [ID_BITS-1:0] slots [DEPTH];
  logic [PTR_W-1:0]   oldest;
  logic [CNT_W-1:0]   held;
  logic [CAP_W-1:0]   capacity;
  logic [ID_BITS-1:0] ident_q;
  logic [PTR_W-1:0]   dump_ptr;
  logic [CNT_W-1:0]   remaining;

  logic [DEPTH-1:0]   match;
  logic [WIDE_W-1:0]  off;
  logic               hit;
  logic [WIDE_W-1:0]  cap_eff;
  logic               evict;
  logic [WIDE_W-1:0]  wr_sum;
  logic [PTR_W-1:0]   wr_idx;
  logic [WIDE_W-1:0]  new_sum;
  logic [PTR_W-1:0]   newest;
  logic [PTR_W-1:0]   oldest_next;
  logic [PTR_W-1:0]   dump_ptr_next;
  logic [CNT_W-1:0]   held_next;
  logic [PTR_W-1:0]   rd_ptr;
  logic [ID_BITS-1:0] rd_data;
  res_t               acc_res;
  res_t               dump_res;

  // Compare the request against every held slot
  always_comb begin
    off   = '0;
    match = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (WIDE_W'(j) >= WIDE_W'(oldest)) begin
        off = WIDE_W'(j) - WIDE_W'(oldest);
      end else begin
        off = WIDE_W'(j) + WIDE_W'(DEPTH) - WIDE_W'(oldest);
      end
      match[j] = (off < WIDE_W'(held)) && (slots[j] == ident_q);
    end
  end

  assign hit = |match;

  // Clamp capacity to the range one to DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_eff = WIDE_W'(1);
    end else if (WIDE_W'(capacity) > WIDE_W'(DEPTH)) begin
      cap_eff = WIDE_W'(DEPTH);
    end else begin
      cap_eff = WIDE_W'(capacity);
    end
  end

  assign evict = (WIDE_W'(held) >= cap_eff);

  // Insert position: one past the newest, which is the old head only when evicting from a full ring
  always_comb begin
    wr_sum = WIDE_W'(oldest) + WIDE_W'(held);
    if (wr_sum >= WIDE_W'(DEPTH)) begin
      wr_sum = wr_sum - WIDE_W'(DEPTH);
    end
    wr_idx = wr_sum[PTR_W-1:0];
  end

  // Newest entry position, start of a dump
  always_comb begin
    new_sum = WIDE_W'(oldest) + WIDE_W'(held) + WIDE_W'(DEPTH - 1);
    if (new_sum >= WIDE_W'(DEPTH)) begin
      new_sum = new_sum - WIDE_W'(DEPTH);
    end
    if (new_sum >= WIDE_W'(DEPTH)) begin
      new_sum = new_sum - WIDE_W'(DEPTH);
    end
    newest = new_sum[PTR_W-1:0];
  end

  assign oldest_next   = (oldest == PTR_W'(DEPTH - 1)) ? '0 : oldest + PTR_W'(1);
  assign dump_ptr_next = (dump_ptr == '0) ? PTR_W'(DEPTH - 1) : dump_ptr - PTR_W'(1);
  assign held_next     = evict ? held : held + CNT_W'(1);

  // Single read port: dump position or eviction victim
  assign rd_ptr  = cmd.emit ? dump_ptr : oldest;
  assign rd_data = slots[rd_ptr];

  assign sts.dump_last = (remaining <= CNT_W'(1));

  // Build access and dump results
  always_comb begin
    acc_res               = '0;
    acc_res.hit           = hit;
    acc_res.evicted_valid = !hit && evict;
    acc_res.evicted_ident = (!hit && evict) ? IDENT_W'(rd_data) : '0;
    acc_res.occupancy     = hit ? OCC_W'(held) : OCC_W'(held_next);
    acc_res.last          = 1'b1;

    dump_res           = '0;
    dump_res.occupancy = OCC_W'(held);
    if (held == '0) begin
      dump_res.set_empty = 1'b1;
      dump_res.last      = 1'b1;
    end else begin
      dump_res.listed_ident = IDENT_W'(rd_data);
      dump_res.last         = (remaining == CNT_W'(1));
    end
  end

  // Capacity register and ring control state
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      oldest   <= '0;
      held     <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.access && !hit) begin
        if (evict) begin
          oldest <= oldest_next;
        end
        held <= held_next;
      end
      done <= cmd.access || cmd.emit;
    end
  end

  // Latch request, step the dump walk, write slots and results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ident_q   <= ID_BITS'(ident);
      dump_ptr  <= newest;
      remaining <= held;
    end else if (cmd.emit) begin
      dump_ptr  <= dump_ptr_next;
      remaining <= remaining - CNT_W'(1);
    end
    if (cmd.access && !hit) begin
      slots[wr_idx] <= ident_q;
    end
    if (cmd.access) begin
      result <= acc_res;
    end else if (cmd.emit) begin
      result <= dump_res;
    end
  end

  `FRIS_ASSERT_IMPL(a_held_max, 1'b1, held <= CNT_W'(DEPTH), "occupancy above built depth")
  `FRIS_ASSERT_IMPL(a_hit_keeps, done && result.hit, $stable(held) && $stable(oldest), "hit changed the ring")
  `FRIS_ASSERT_IMPL(a_evict_keeps, done && result.evicted_valid, $stable(held), "eviction changed occupancy")

endmodule

// ===== rtl/fifo_replacement_id_set.sv =====
// Access: accepted when start is seen while not busy; the ACCESS state registers the
// result, and a new request is taken only once busy drops. Dump of N entries: N results,
// one per cycle, newest first (empty: one result, as an access); the slot read port walks
// the ring one entry per cycle. Results are strobed by done for one cycle; no receiver stall.
// Synchronous active-high reset empties the set and sets capacity to 16.
// Top level; depends on fris_pkg, fris_ctrl and fris_dp.
module fifo_replacement_id_set
  import fris_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  req_t             request,
  output logic             done,
  output res_t             result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  fris_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_dump (request.operation),
    .sts     (sts),
    .busy    (busy),
    .cmd     (cmd)
  );

  fris_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .ident    (request.ident),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .sts      (sts),
    .done     (done),
    .result   (result)
  );

endmodule
